[design/scatr_pkg.sv]
// Shared types and constants for the smart card ATR parser.
// No dependencies; imported by every module of the block.
package scatr_pkg;

  // Longest ATR accepted before a length overflow is flagged
  localparam int unsigned MaxAtrBytes = 33;
  localparam int unsigned CountW      = 6;

  // Convention bytes (TS)
  localparam logic [7:0] TsDirect  = 8'h3b;
  localparam logic [7:0] TsInverse = 8'h03;

  typedef enum logic [2:0] {
    KindTs    = 3'd0,
    KindT0    = 3'd1,
    KindIface = 3'd2,
    KindTd    = 3'd3,
    KindHist  = 3'd4,
    KindTck   = 3'd5,
    KindNone  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatBadTs    = 2'd1,
    StatOverflow = 2'd2,
    StatIgnored  = 2'd3
  } status_e;

  // One result word
  typedef struct packed {
    logic [CountW-1:0] position;
    logic [7:0]        stored_byte;
    kind_e             byte_kind;
    logic              atr_done;
    logic [CountW-1:0] atr_length;
    status_e           parse_status;
    logic              inverse_mode;
  } result_t;

endpackage

[design/scatr_step.sv]
// Parser state registers and the per-word decision logic of the ATR parser.
// Depends on scatr_pkg.
module scatr_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              action_i,
  input  logic [7:0]        rx_byte_i,
  output scatr_pkg::result_t result_o
);
  import scatr_pkg::*;

  typedef enum logic [2:0] {
    PhTs    = 3'd0,
    PhT0    = 3'd1,
    PhGroup = 3'd2,
    PhTail  = 3'd3,
    PhIdle  = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  logic              inverse_q, inverse_d;
  logic [2:0]        group_left_q, group_left_d;
  logic              has_td_q, has_td_d;
  logic [3:0]        hist_q, hist_d;
  logic              tck_q, tck_d;
  logic [4:0]        tail_q, tail_d;
  logic [CountW-1:0] count_q, count_d;

  logic              open_en;
  logic [7:0]        open_y;
  logic [2:0]        open_n;
  logic [2:0]        gl_dec;
  logic [4:0]        tail_dec;
  logic              fin;
  logic [7:0]        fmt_y;
  result_t           res;

  // Read a format byte in the current convention: reverse and invert if inverse
  function automatic logic [7:0] decode(input logic [7:0] b, input logic inv);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return inv ? ~r : b;
  endfunction

  assign fmt_y    = decode(rx_byte_i, inverse_q);
  assign gl_dec   = (group_left_q != 3'd0) ? group_left_q - 3'd1 : 3'd0;
  assign tail_dec = (tail_q != 5'd0) ? tail_q - 5'd1 : 5'd0;
  assign open_n   = {2'b00, open_y[4]} + {2'b00, open_y[5]}
                  + {2'b00, open_y[6]} + {2'b00, open_y[7]};

  // Decide the result and the next state for one word
  always_comb begin
    phase_d      = phase_q;
    inverse_d    = inverse_q;
    group_left_d = group_left_q;
    has_td_d     = has_td_q;
    hist_d       = hist_q;
    tck_d        = tck_q;
    tail_d       = tail_q;
    count_d      = count_q;
    open_en      = 1'b0;
    open_y       = 8'h00;
    fin          = 1'b0;
    res              = '0;
    res.stored_byte  = rx_byte_i;
    res.byte_kind    = KindNone;
    res.parse_status = StatOk;

    if (action_i) begin
      // Card reset: wipe everything and echo nothing
      phase_d         = PhTs;
      inverse_d       = 1'b0;
      group_left_d    = 3'd0;
      has_td_d        = 1'b0;
      hist_d          = 4'd0;
      tck_d           = 1'b0;
      tail_d          = 5'd0;
      count_d         = '0;
      res.stored_byte = 8'h00;
    end else if (phase_q == PhIdle) begin
      res.parse_status = StatIgnored;
    end else if (count_q >= CountW'(MaxAtrBytes)) begin
      res.parse_status = StatOverflow;
      res.atr_done     = 1'b1;
      res.atr_length   = CountW'(MaxAtrBytes);
      phase_d          = PhIdle;
    end else begin
      res.position = count_q;
      unique case (phase_q)
        PhTs: begin
          res.byte_kind = KindTs;
          if (rx_byte_i == TsInverse || rx_byte_i == TsDirect) begin
            inverse_d = (rx_byte_i == TsInverse);
            phase_d   = PhT0;
            count_d   = count_q + CountW'(1);
          end else begin
            res.parse_status = StatBadTs;
            res.atr_done     = 1'b1;
            phase_d          = PhIdle;
          end
        end
        PhT0: begin
          res.byte_kind = KindT0;
          count_d       = count_q + CountW'(1);
          hist_d        = fmt_y[3:0];
          open_en       = 1'b1;
          open_y        = fmt_y;
        end
        PhGroup: begin
          count_d      = count_q + CountW'(1);
          group_left_d = gl_dec;
          if (gl_dec == 3'd0 && has_td_q) begin
            res.byte_kind = KindTd;
            if (fmt_y[3:0] != 4'd0) begin
              tck_d = 1'b1;
            end
            open_en = 1'b1;
            open_y  = fmt_y;
          end else begin
            res.byte_kind = KindIface;
            open_en       = (gl_dec == 3'd0);
          end
        end
        PhTail: begin
          count_d       = count_q + CountW'(1);
          res.byte_kind = (tail_q == 5'd1 && tck_q) ? KindTck : KindHist;
          tail_d        = tail_dec;
          if (tail_dec == 5'd0) begin
            phase_d = PhIdle;
            fin     = 1'b1;
          end
        end
        default: begin
          res.parse_status = StatIgnored;
          res.position     = '0;
          phase_d          = PhIdle;
        end
      endcase

      // Open the next interface group, or the tail when the group is empty
      if (open_en) begin
        if (open_n != 3'd0) begin
          group_left_d = open_n;
          has_td_d     = open_y[7];
          phase_d      = PhGroup;
        end else begin
          tail_d = {1'b0, hist_d} + {4'b0000, tck_d};
          if (tail_d == 5'd0) begin
            phase_d = PhIdle;
            fin     = 1'b1;
          end else begin
            phase_d = PhTail;
          end
        end
      end

      if (fin) begin
        res.atr_done   = 1'b1;
        res.atr_length = count_d;
      end
    end
    res.inverse_mode = inverse_d;
  end

  assign result_o = res;

  // Hold parser state; advance on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhTs;
      inverse_q    <= 1'b0;
      group_left_q <= 3'd0;
      has_td_q     <= 1'b0;
      hist_q       <= 4'd0;
      tck_q        <= 1'b0;
      tail_q       <= 5'd0;
      count_q      <= '0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      inverse_q    <= inverse_d;
      group_left_q <= group_left_d;
      has_td_q     <= has_td_d;
      hist_q       <= hist_d;
      tck_q        <= tck_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
    end
  end

  // Restart clears the count and the convention
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && action_i) |=> (count_q == '0 && !inverse_q && phase_q == PhTs))
    else $error("restart did not clear parser state");

  // The count never passes the ATR limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxAtrBytes))
    else $error("byte count beyond ATR limit");

  // Inside an interface group at least one byte is always still due
  a_group_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhGroup) |-> (group_left_q != 3'd0))
    else $error("interface group with nothing due");

  // A normal completion reports a length one past the final position
  a_done_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.atr_done && res.parse_status == StatOk)
      |-> (res.atr_length == res.position + CountW'(1)))
    else $error("completion length does not match position");

endmodule

[design/scatr_out_reg.sv]
// Result register of the ATR parser: holds one result word toward the receiver.
// Depends on scatr_pkg.
module scatr_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  scatr_pkg::result_t data_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               ready_i,
  output scatr_pkg::result_t data_o
);
  import scatr_pkg::*;

  logic    valid_q;
  result_t data_q;

  // Free when empty or when the held word leaves this cycle
  assign ready_o = !valid_q || ready_i;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  // Capture a new result word
  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // A held result word stays while the receiver stalls
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> valid_q)
    else $error("held result word dropped while stalled");

endmodule

[design/smart_card_atr_parser.sv]
// Smart card ATR parser: accepts ATR bytes and returns one classified result each.
// Uses scatr_pkg, scatr_step and scatr_out_reg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word: action_i = 1 starts
//   a new ATR (card reset), action_i = 0 delivers rx_byte_i from the card.
//   Output channel (out_valid_o/out_ready_i) returns exactly one result word
//   per input word: position, echoed byte, byte kind, done flag with total
//   length, parse status and the detected convention.
//   A word accepted at a clock edge appears on the output after that edge.
//   Throughput is one word per cycle unless the receiver stalls, set by the single
//   result register; the parser state updates in the same cycle a word is taken.
//   When the receiver stalls, the result register holds its word and
//   in_ready_o drops until it is taken; no word is lost.
//   Reset puts the parser in the expect-TS phase with direct convention and
//   empties the result register.
module smart_card_atr_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [5:0] position_o,
  output logic [7:0] stored_byte_o,
  output logic [2:0] byte_kind_o,
  output logic       atr_done_o,
  output logic [5:0] atr_length_o,
  output logic [1:0] parse_status_o,
  output logic       inverse_mode_o
);
  import scatr_pkg::*;

  logic    fire;
  result_t step_res;
  result_t out_res;

  assign fire = in_valid_i && in_ready_o;

  // Decide each word against the parser state
  scatr_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .action_i  (action_i),
    .rx_byte_i (rx_byte_i),
    .result_o  (step_res)
  );

  // Register the result toward the receiver
  scatr_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .data_i  (step_res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  // Unpack the result word onto the ports
  assign position_o     = out_res.position;
  assign stored_byte_o  = out_res.stored_byte;
  assign byte_kind_o    = out_res.byte_kind;
  assign atr_done_o     = out_res.atr_done;
  assign atr_length_o   = out_res.atr_length;
  assign parse_status_o = out_res.parse_status;
  assign inverse_mode_o = out_res.inverse_mode;

  // Each accepted word shows up as a result in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("accepted word produced no result");

  // A restart result carries nothing but its kind
  a_restart_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && action_i) |=> (byte_kind_o == KindNone && parse_status_o == StatOk
                            && stored_byte_o == 8'h00 && !atr_done_o))
    else $error("restart result not clean");

endmodule
